// File: rtl/pfpq_pkg.sv
// Shared codes and control types for the pair frequency priority queue.
`default_nettype none

package pfpq_pkg;

  localparam int unsigned FUNC_BITS = 2;
  localparam int unsigned POS_BITS  = 20;
  localparam int unsigned AGE_BITS  = 32;

  localparam logic [FUNC_BITS-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_DELETE  = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_EXTRACT = 2'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_NOP     = 2'd3;

  typedef struct packed {
    logic load;    // capture item, restart trackers
    logic clr;     // write an invalid entry at the sweep address
    logic rd;      // issue a table read at the sweep address
    logic commit;  // apply the operation and load the result
  } pfpq_cmd_t;

  typedef struct packed {
    logic addr_last;
  } pfpq_sts_t;

endpackage

`default_nettype wire

// File: rtl/pfpq_ctrl.sv
// Sequencer: reset clearing pass, table scan, commit and output handshake.
`default_nettype none

module pfpq_ctrl (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire  [pfpq_pkg::FUNC_BITS-1:0]        func_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  input  pfpq_pkg::pfpq_sts_t                   sts_i,
  output pfpq_pkg::pfpq_cmd_t                   cmd_o
);
  import pfpq_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.addr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (func_i == FUNC_NOP) ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd = 1'b1;
        if (sts_i.addr_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
    else $error("result raised outside commit");

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SCAN || state_q == ST_COMMIT))
    else $error("accepted item did not start");

  a_drain_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> (state_q == ST_COMMIT))
    else $error("drain did not lead to commit");

endmodule

`default_nettype wire

// File: rtl/pfpq_dp.sv
// Datapath: entry table memory, scan trackers, commit logic and result register.
`default_nettype none

module pfpq_dp #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned SYMBOL_BITS = 16,
  parameter int unsigned COUNT_BITS  = 20
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  pfpq_pkg::pfpq_cmd_t                cmd_i,
  output pfpq_pkg::pfpq_sts_t                sts_o,
  input  wire  [pfpq_pkg::FUNC_BITS-1:0]     func_i,
  input  wire  [SYMBOL_BITS-1:0]             left_symbol_i,
  input  wire  [SYMBOL_BITS-1:0]             right_symbol_i,
  input  wire  [pfpq_pkg::POS_BITS-1:0]      first_position_i,
  input  wire  [COUNT_BITS-1:0]              new_frequency_i,
  output logic                               found_o,
  output logic                               table_full_o,
  output logic [SYMBOL_BITS-1:0]             out_left_symbol_o,
  output logic [SYMBOL_BITS-1:0]             out_right_symbol_o,
  output logic [pfpq_pkg::POS_BITS-1:0]      out_first_position_o,
  output logic [COUNT_BITS-1:0]              out_frequency_o
);
  import pfpq_pkg::*;

  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam int unsigned KEY_W   = 2 * SYMBOL_BITS;
  localparam int unsigned ENTRY_W = 1 + KEY_W + POS_BITS + COUNT_BITS + AGE_BITS;
  localparam int unsigned CNT_LSB = AGE_BITS;
  localparam int unsigned POS_LSB = CNT_LSB + COUNT_BITS;
  localparam int unsigned KEY_LSB = POS_LSB + POS_BITS;

  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [ENTRY_W-1:0] rdata_q;

  // item registers
  logic [FUNC_BITS-1:0]  func_q;
  logic [KEY_W-1:0]      key_q;
  logic [POS_BITS-1:0]   pos_q;
  logic [COUNT_BITS-1:0] freq_q;

  logic [IDX_W-1:0] addr_q, addr_d;
  logic [IDX_W-1:0] ridx_q;
  logic             rdv_q;
  logic [AGE_BITS-1:0] age_q, age_d;

  // trackers
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic              free_q, free_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic              best_q, best_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [COUNT_BITS-1:0] best_cnt_q, best_cnt_d;
  logic [AGE_BITS-1:0]   best_dist_q, best_dist_d;
  logic [KEY_W-1:0]      best_key_q, best_key_d;
  logic [POS_BITS-1:0]   best_pos_q, best_pos_d;

  // read entry fields
  logic                  e_vld;
  logic [KEY_W-1:0]      e_key;
  logic [POS_BITS-1:0]   e_pos;
  logic [COUNT_BITS-1:0] e_cnt;
  logic [AGE_BITS-1:0]   e_dist;

  // write port
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               w_vld;

  // result
  logic                  found_d, full_d, ext_d;

  assign e_vld  = rdata_q[ENTRY_W-1];
  assign e_key  = rdata_q[KEY_LSB +: KEY_W];
  assign e_pos  = rdata_q[POS_LSB +: POS_BITS];
  assign e_cnt  = rdata_q[CNT_LSB +: COUNT_BITS];
  assign e_dist = age_q - rdata_q[AGE_BITS-1:0];

  assign sts_o.addr_last = (addr_q == IDX_W'(CAPACITY - 1));

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.rd || cmd_i.clr) begin
      addr_d = sts_o.addr_last ? '0 : addr_q + IDX_W'(1);
    end
  end

  always_comb begin
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    best_cnt_d  = best_cnt_q;
    best_dist_d = best_dist_q;
    best_key_d  = best_key_q;
    best_pos_d  = best_pos_q;
    if (cmd_i.load) begin
      hit_d  = 1'b0;
      free_d = 1'b0;
      best_d = 1'b0;
    end else if (rdv_q) begin
      if (e_vld && (e_key == key_q) && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = ridx_q;
      end
      if (!e_vld && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = ridx_q;
      end
      if (e_vld && (!best_q || (e_cnt > best_cnt_q) ||
                    ((e_cnt == best_cnt_q) && (e_dist > best_dist_q)))) begin
        best_d      = 1'b1;
        best_idx_d  = ridx_q;
        best_cnt_d  = e_cnt;
        best_dist_d = e_dist;
        best_key_d  = e_key;
        best_pos_d  = e_pos;
      end
    end
  end

  // clear writes and commit decision
  always_comb begin
    we      = 1'b0;
    waddr   = addr_q;
    w_vld   = 1'b0;
    age_d   = age_q;
    found_d = 1'b0;
    full_d  = 1'b0;
    ext_d   = 1'b0;
    if (cmd_i.clr) begin
      we = 1'b1;
    end else if (cmd_i.commit) begin
      case (func_q)
        FUNC_INSERT: begin
          if (hit_q) begin
            found_d = 1'b1;
            we      = 1'b1;
            waddr   = hit_idx_q;
            w_vld   = (freq_q != '0);
            if (freq_q != '0) age_d = age_q + AGE_BITS'(1);
          end else if (freq_q != '0) begin
            if (free_q) begin
              we    = 1'b1;
              waddr = free_idx_q;
              w_vld = 1'b1;
              age_d = age_q + AGE_BITS'(1);
            end else begin
              full_d = 1'b1;
            end
          end
        end
        FUNC_DELETE: begin
          if (hit_q) begin
            found_d = 1'b1;
            we      = 1'b1;
            waddr   = hit_idx_q;
          end
        end
        FUNC_EXTRACT: begin
          if (best_q && (best_cnt_q >= COUNT_BITS'(2))) begin
            found_d = 1'b1;
            ext_d   = 1'b1;
            we      = 1'b1;
            waddr   = best_idx_q;
          end
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  assign wdata = {w_vld, key_q, pos_q, freq_q, age_q};

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.rd) rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      rdv_q  <= 1'b0;
      age_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      best_q <= 1'b0;
    end else begin
      addr_q <= addr_d;
      rdv_q  <= cmd_i.rd;
      age_q  <= age_d;
      hit_q  <= hit_d;
      free_q <= free_d;
      best_q <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q      <= addr_q;
    hit_idx_q   <= hit_idx_d;
    free_idx_q  <= free_idx_d;
    best_idx_q  <= best_idx_d;
    best_cnt_q  <= best_cnt_d;
    best_dist_q <= best_dist_d;
    best_key_q  <= best_key_d;
    best_pos_q  <= best_pos_d;
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q  <= {left_symbol_i, right_symbol_i};
      pos_q  <= first_position_i;
      freq_q <= new_frequency_i;
    end
    if (cmd_i.commit) begin
      found_o              <= found_d;
      table_full_o         <= full_d;
      out_left_symbol_o    <= ext_d ? best_key_q[KEY_W-1 -: SYMBOL_BITS] : '0;
      out_right_symbol_o   <= ext_d ? best_key_q[SYMBOL_BITS-1:0] : '0;
      out_first_position_o <= ext_d ? best_pos_q : '0;
      out_frequency_o      <= ext_d ? best_cnt_q : '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pair_frequency_priority_queue.sv
// Pair frequency priority queue: top level joining sequencer and datapath.
//
// Input channel (in_valid_i/in_ready_o) takes one item: func 0 inserts or
// updates a pair (frequency zero removes it), func 1 deletes a pair, func 2
// extracts the oldest pair of highest frequency when that frequency is at
// least two, func 3 does nothing. Output channel (out_valid_o/out_ready_i)
// returns exactly one result item per input item, in order.
// Every operation but func 3 sweeps the whole table through one memory read
// port, one entry per cycle; the result is registered at commit, after the
// scan and the drain state (func 3 goes straight to commit), and a new item
// is taken only once the sequencer is back in idle after that commit.
// The result register separates the channels: the next item is accepted and
// scanned while a result waits; its commit holds until the register frees.
// After reset the table is swept once to invalidate every entry, during
// which in_ready_o stays low.
`default_nettype none

module pair_frequency_priority_queue #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned SYMBOL_BITS = 16,
  parameter int unsigned COUNT_BITS  = 20
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [pfpq_pkg::FUNC_BITS-1:0] func_i,
  input  wire  [SYMBOL_BITS-1:0]         left_symbol_i,
  input  wire  [SYMBOL_BITS-1:0]         right_symbol_i,
  input  wire  [pfpq_pkg::POS_BITS-1:0]  first_position_i,
  input  wire  [COUNT_BITS-1:0]          new_frequency_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic                           found_o,
  output logic                           table_full_o,
  output logic [SYMBOL_BITS-1:0]         out_left_symbol_o,
  output logic [SYMBOL_BITS-1:0]         out_right_symbol_o,
  output logic [pfpq_pkg::POS_BITS-1:0]  out_first_position_o,
  output logic [COUNT_BITS-1:0]          out_frequency_o
);
  import pfpq_pkg::*;

  pfpq_cmd_t cmd;
  pfpq_sts_t sts;

  pfpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfpq_dp #(
    .CAPACITY    (CAPACITY),
    .SYMBOL_BITS (SYMBOL_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .func_i               (func_i),
    .left_symbol_i        (left_symbol_i),
    .right_symbol_i       (right_symbol_i),
    .first_position_i     (first_position_i),
    .new_frequency_i      (new_frequency_i),
    .found_o              (found_o),
    .table_full_o         (table_full_o),
    .out_left_symbol_o    (out_left_symbol_o),
    .out_right_symbol_o   (out_right_symbol_o),
    .out_first_position_o (out_first_position_o),
    .out_frequency_o      (out_frequency_o)
  );

endmodule

`default_nettype wire

// File: test/pfpq_tb_pkg.sv
`timescale 1ns / 100ps
// Item types and the scoreboard class that predicts pair table results.
package pfpq_tb_pkg;

  import pfpq_pkg::*;

  localparam int DEPTH = 256;
  localparam int SYM_W = 16;
  localparam int CNT_W = 20;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [SYM_W-1:0]     left;
    logic [SYM_W-1:0]     right;
    logic [POS_BITS-1:0]  pos;
    logic [CNT_W-1:0]     freq;
  } pair_op_t;

  typedef struct packed {
    logic                found;
    logic                full;
    logic [SYM_W-1:0]    left;
    logic [SYM_W-1:0]    right;
    logic [POS_BITS-1:0] pos;
    logic [CNT_W-1:0]    freq;
  } pair_result_t;

  class pair_queue_checker;
    bit                  used[DEPTH];
    logic [2*SYM_W-1:0]  key_tab[DEPTH];
    logic [POS_BITS-1:0] pos_tab[DEPTH];
    logic [CNT_W-1:0]    cnt_tab[DEPTH];
    logic [AGE_BITS-1:0] age_tab[DEPTH];
    logic [AGE_BITS-1:0] stamp;
    pair_result_t        awaited[$];
    int                  errors;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      stamp  = '0;
      errors = 0;
    endfunction

    function int lookup(logic [2*SYM_W-1:0] key);
      for (int i = 0; i < DEPTH; i++) begin
        if (used[i] && key_tab[i] == key) return i;
      end
      return -1;
    endfunction

    function void store(int idx, logic [2*SYM_W-1:0] key, logic [POS_BITS-1:0] pos,
                        logic [CNT_W-1:0] cnt);
      used[idx]    = 1'b1;
      key_tab[idx] = key;
      pos_tab[idx] = pos;
      cnt_tab[idx] = cnt;
      age_tab[idx] = stamp;
      stamp        = stamp + 1'b1;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Predict the result of one accepted item and queue it.
    function void take_item(pair_op_t op);
      pair_result_t        res;
      int                  hit;
      int                  slot;
      int                  best;
      logic [2*SYM_W-1:0]  key;
      logic [AGE_BITS-1:0] age_gap;
      logic [AGE_BITS-1:0] best_dist;
      logic [CNT_W-1:0]    best_cnt;
      res = '0;
      key = {op.left, op.right};
      case (op.func)
        FUNC_INSERT: begin
          hit = lookup(key);
          if (hit >= 0) begin
            res.found = 1'b1;
            if (op.freq == '0) used[hit] = 1'b0;
            else store(hit, key, op.pos, op.freq);
          end else if (op.freq != '0) begin
            slot = -1;
            for (int i = DEPTH - 1; i >= 0; i--) begin
              if (!used[i]) slot = i;
            end
            if (slot >= 0) store(slot, key, op.pos, op.freq);
            else res.full = 1'b1;
          end
        end
        FUNC_DELETE: begin
          hit = lookup(key);
          if (hit >= 0) begin
            used[hit] = 1'b0;
            res.found = 1'b1;
          end
        end
        FUNC_EXTRACT: begin
          best      = -1;
          best_cnt  = '0;
          best_dist = '0;
          for (int i = 0; i < DEPTH; i++) begin
            if (used[i]) begin
              age_gap = stamp - age_tab[i];
              if (best < 0 || cnt_tab[i] > best_cnt ||
                  (cnt_tab[i] == best_cnt && age_gap > best_dist)) begin
                best      = i;
                best_cnt  = cnt_tab[i];
                best_dist = age_gap;
              end
            end
          end
          if (best >= 0 && best_cnt >= CNT_W'(2)) begin
            res.found  = 1'b1;
            res.left   = key_tab[best][2*SYM_W-1:SYM_W];
            res.right  = key_tab[best][SYM_W-1:0];
            res.pos    = pos_tab[best];
            res.freq   = best_cnt;
            used[best] = 1'b0;
          end
        end
        default: ;
      endcase
      awaited = {awaited, res};
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("mismatch: %s", what);
    endtask

    task check_result(pair_result_t got);
      pair_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited, found=%0b", got.found));
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found)
        report($sformatf("found %0b, expected %0b", got.found, want.found));
      if (got.full !== want.full)
        report($sformatf("table_full %0b, expected %0b", got.full, want.full));
      if (got.left !== want.left)
        report($sformatf("left symbol %h, expected %h", got.left, want.left));
      if (got.right !== want.right)
        report($sformatf("right symbol %h, expected %h", got.right, want.right));
      if (got.pos !== want.pos)
        report($sformatf("first position %h, expected %h", got.pos, want.pos));
      if (got.freq !== want.freq)
        report($sformatf("frequency %h, expected %h", got.freq, want.freq));
    endtask
  endclass

endpackage

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, item drivers and the run sequence.
module tb;

  import pfpq_pkg::*;
  import pfpq_tb_pkg::*;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic [FUNC_BITS-1:0] func_i           = '0;
  logic [SYM_W-1:0]     left_symbol_i    = '0;
  logic [SYM_W-1:0]     right_symbol_i   = '0;
  logic [POS_BITS-1:0]  first_position_i = '0;
  logic [CNT_W-1:0]     new_frequency_i  = '0;
  logic                 out_ready_i      = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 found_o;
  logic                 table_full_o;
  logic [SYM_W-1:0]     out_left_symbol_o;
  logic [SYM_W-1:0]     out_right_symbol_o;
  logic [POS_BITS-1:0]  out_first_position_o;
  logic [CNT_W-1:0]     out_frequency_o;

  pair_queue_checker sb;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  pair_frequency_priority_queue #(
    .CAPACITY    (DEPTH),
    .SYMBOL_BITS (SYM_W),
    .COUNT_BITS  (CNT_W)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .func_i               (func_i),
    .left_symbol_i        (left_symbol_i),
    .right_symbol_i       (right_symbol_i),
    .first_position_i     (first_position_i),
    .new_frequency_i      (new_frequency_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .found_o              (found_o),
    .table_full_o         (table_full_o),
    .out_left_symbol_o    (out_left_symbol_o),
    .out_right_symbol_o   (out_right_symbol_o),
    .out_first_position_o (out_first_position_o),
    .out_frequency_o      (out_frequency_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic pair_op_t make_op(logic [FUNC_BITS-1:0] func, logic [SYM_W-1:0] left,
                                       logic [SYM_W-1:0] right, logic [POS_BITS-1:0] pos,
                                       logic [CNT_W-1:0] freq);
    pair_op_t op;
    op.func  = func;
    op.left  = left;
    op.right = right;
    op.pos   = pos;
    op.freq  = freq;
    return op;
  endfunction

  function automatic logic [CNT_W-1:0] pick_freq(bit allow_zero);
    int r;
    r = $urandom_range(99);
    if (allow_zero && r < 10) return '0;
    if (r < 25) return CNT_W'(1);
    if (r < 80) return CNT_W'($urandom_range(6, 2));
    return CNT_W'($urandom);
  endfunction

  task automatic send_op(input pair_op_t op);
    int gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(99) < 19) gap++;
      if ($urandom_range(99) < 4) gap += $urandom_range(300);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= op.func;
    left_symbol_i    <= op.left;
    right_symbol_i   <= op.right;
    first_position_i <= op.pos;
    new_frequency_i  <= op.freq;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_item(op);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : receiver
    int           hold_left;
    pair_result_t got;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 1500;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= quiet || ($urandom_range(99) >= 19);
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.found = found_o;
        got.full  = table_full_o;
        got.left  = out_left_symbol_o;
        got.right = out_right_symbol_o;
        got.pos   = out_first_position_o;
        got.freq  = out_frequency_o;
        sb.check_result(got);
      end
    end
  end

  initial begin : stimulus
    pair_op_t           op;
    logic [2*SYM_W-1:0] pool[12];
    logic [2*SYM_W-1:0] filled[$];
    logic [2*SYM_W-1:0] key;
    int                 pick;
    sb = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_op(make_op(FUNC_EXTRACT, 16'h0000, 16'h0000, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_DELETE,  16'h0000, 16'h0000, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_INSERT,  16'hffff, 16'hffff, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_INSERT,  16'h0000, 16'h0000, 20'h00000, 20'h00001));
    send_op(make_op(FUNC_EXTRACT, 16'h0000, 16'h0000, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_INSERT,  16'hffff, 16'hffff, 20'hfffff, 20'hfffff));
    send_op(make_op(FUNC_INSERT,  16'h1234, 16'habcd, 20'h00005, 20'hfffff));
    send_op(make_op(FUNC_EXTRACT, 16'h0000, 16'h0000, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_INSERT,  16'h0000, 16'h0000, 20'h00007, 20'hfffff));
    send_op(make_op(FUNC_EXTRACT, 16'hffff, 16'hffff, 20'hfffff, 20'hfffff));
    send_op(make_op(FUNC_INSERT,  16'h0000, 16'h0000, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_NOP,     16'hffff, 16'hffff, 20'hfffff, 20'hfffff));
    send_op(make_op(FUNC_INSERT,  16'h0005, 16'h0006, 20'h00100, 20'h00002));
    send_op(make_op(FUNC_INSERT,  16'h0006, 16'h0005, 20'h00200, 20'h00002));
    send_op(make_op(FUNC_DELETE,  16'h0005, 16'h0006, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_DELETE,  16'h0005, 16'h0006, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_EXTRACT, 16'h0000, 16'h0000, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_INSERT,  16'h8000, 16'h0001, 20'h80000, 20'h00003));
    send_op(make_op(FUNC_INSERT,  16'h0001, 16'h8000, 20'h00001, 20'h00003));
    send_op(make_op(FUNC_INSERT,  16'h8000, 16'h0001, 20'h00002, 20'h00003));
    send_op(make_op(FUNC_EXTRACT, 16'h0000, 16'h0000, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_EXTRACT, 16'h0000, 16'h0000, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_EXTRACT, 16'h0000, 16'h0000, 20'h00000, 20'h00000));
    send_op(make_op(FUNC_DELETE,  16'hffff, 16'h0000, 20'hfffff, 20'hfffff));
    wait_drained();

    // small pair pool: frequent hits, updates and extracts
    pool[0] = 32'h0000_0000;
    pool[1] = 32'hffff_ffff;
    pool[2] = 32'hffff_0000;
    pool[3] = 32'h0000_ffff;
    for (int i = 4; i < 12; i++) pool[i] = (2*SYM_W)'($urandom);
    for (int n = 0; n < 100; n++) begin
      quiet = (n >= 55 && n < 80);
      if (n == 30) hold_req = 1'b1;
      key  = pool[$urandom_range(11)];
      pick = $urandom_range(99);
      op   = make_op(pick < 50 ? FUNC_INSERT : pick < 65 ? FUNC_DELETE :
                     pick < 95 ? FUNC_EXTRACT : FUNC_NOP,
                     key[2*SYM_W-1:SYM_W], key[SYM_W-1:0], POS_BITS'($urandom),
                     pick_freq(1'b1));
      send_op(op);
    end
    wait_drained();
    quiet = 1'b0;

    // fill the table past capacity
    for (int n = 0; n < 280; n++) begin
      if ($urandom_range(99) < 6 && filled.size() > 0) begin
        key = filled[$urandom_range(filled.size() - 1)];
        op  = make_op(FUNC_INSERT, key[2*SYM_W-1:SYM_W], key[SYM_W-1:0],
                      POS_BITS'($urandom), pick_freq(1'b1));
      end else begin
        key = (2*SYM_W)'($urandom);
        filled = {filled, key};
        op  = make_op(FUNC_INSERT, key[2*SYM_W-1:SYM_W], key[SYM_W-1:0],
                      POS_BITS'($urandom), pick_freq(1'b0));
      end
      send_op(op);
    end

    for (int n = 0; n < 30; n++) begin
      pick = $urandom_range(99);
      if (pick < 60 && pick >= 35 && $urandom_range(99) < 70)
        key = filled[$urandom_range(filled.size() - 1)];
      else
        key = (2*SYM_W)'($urandom);
      op = make_op(pick < 35 ? FUNC_EXTRACT : pick < 60 ? FUNC_DELETE :
                   pick < 95 ? FUNC_INSERT : FUNC_NOP,
                   key[2*SYM_W-1:SYM_W], key[SYM_W-1:0], POS_BITS'($urandom),
                   pick < 90 ? pick_freq(1'b0) : '0);
      send_op(op);
    end
    wait_drained();
    repeat (DEPTH + 8) @(posedge clk_i);

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
rtl/pfpq_pkg.sv
rtl/pfpq_ctrl.sv
rtl/pfpq_dp.sv
rtl/pair_frequency_priority_queue.sv
test/pfpq_tb_pkg.sv
test/tb.sv
